// File: sv/rpn_dse_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// RPN stack evaluator package
// Character codes, widths and the controller state type.
// ----------------------------------------------------------------------------
package rpn_dse_pkg;

    localparam int DATA_W    = 32;
    localparam int SYM_W     = 8;
    localparam int DIV_CNT_W = 5;
    localparam int RADIX     = 10;

    localparam logic [SYM_W-1:0] CH_PLUS  = 8'h2B;
    localparam logic [SYM_W-1:0] CH_MINUS = 8'h2D;
    localparam logic [SYM_W-1:0] CH_MUL   = 8'h2A;
    localparam logic [SYM_W-1:0] CH_DIV   = 8'h2F;
    localparam logic [SYM_W-1:0] CH_ZERO  = 8'h30;

    typedef logic [DATA_W-1:0] data_t;
    typedef logic [SYM_W-1:0]  sym_t;

    typedef enum logic [9:0] {
        S_IDLE   = 10'b00_0000_0001,
        S_DECODE = 10'b00_0000_0010,
        S_RD_B   = 10'b00_0000_0100,
        S_RD_A   = 10'b00_0000_1000,
        S_EXEC   = 10'b00_0001_0000,
        S_DIV    = 10'b00_0010_0000,
        S_FIX    = 10'b00_0100_0000,
        S_WR     = 10'b00_1000_0000,
        S_FINISH = 10'b01_0000_0000,
        S_OUT    = 10'b10_0000_0000
    } state_t;

endpackage

// File: sv/rpn_digit_stack_evaluator_core.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// RPN digit stack evaluator
// Evaluates reverse Polish expressions fed one character per word, on a
// value stack held in a synchronous single-port-write, one-read memory.
//
//   channel | direction | ports                                   | word
//   s_      | in        | s_symbol, s_end_of_expression           | one char
//   m_      | out       | m_answer, m_answer_valid, m_divide_by_  | one answer
//           |           | zero_seen, m_stack_overflow_seen        |
//
// Each word passes S_DECODE; + - * also read two operands, and / adds the 32-step
// restoring divider (S_DIV, S_FIX); end of expression adds S_OUT for the pop.
// The stack memory has a registered read; operands are read back one per cycle.
// Reset: synchronous, active low; clears depth, flags and control, no sweep.
// A waiting answer does not block input until the next end of expression.
// ----------------------------------------------------------------------------
module rpn_digit_stack_evaluator_core
    import rpn_dse_pkg::*;
#(
    parameter int STACK_DEPTH = 16
) (
    input  logic                     aclk,
    input  logic                     aresetn,
    input  logic                     s_valid,
    output logic                     s_ready,
    input  logic [SYM_W-1:0]         s_symbol,
    input  logic                     s_end_of_expression,
    output logic                     m_valid,
    input  logic                     m_ready,
    output logic signed [DATA_W-1:0] m_answer,
    output logic                     m_answer_valid,
    output logic                     m_divide_by_zero_seen,
    output logic                     m_stack_overflow_seen
);

    localparam int AW = (STACK_DEPTH > 1) ? $clog2(STACK_DEPTH) : 1;
    localparam int DW = $clog2(STACK_DEPTH + 1);

    data_t mem [STACK_DEPTH];
    data_t rd_data_reg;

    logic          mem_we;
    logic [AW-1:0] mem_waddr;
    data_t         mem_wdata;
    logic          mem_re;
    logic [AW-1:0] mem_raddr;

    state_t                 state_reg, state_next;
    sym_t                   sym_reg, sym_next;
    logic                   eoe_reg, eoe_next;
    logic [DW-1:0]          depth_reg, depth_next;
    logic                   dz_reg, dz_next;
    logic                   ov_reg, ov_next;
    data_t                  a_reg, a_next;
    data_t                  b_reg, b_next;
    data_t                  res_reg, res_next;
    data_t                  rem_reg, rem_next;
    data_t                  quo_reg, quo_next;
    data_t                  dvs_reg, dvs_next;
    logic                   neg_reg, neg_next;
    logic [DIV_CNT_W-1:0]   cnt_reg, cnt_next;
    logic                   m_valid_reg, m_valid_next;
    data_t                  m_answer_reg, m_answer_next;
    logic                   m_aval_reg, m_aval_next;
    logic                   m_dz_reg, m_dz_next;
    logic                   m_ov_reg, m_ov_next;

    logic                   is_digit;
    logic                   is_op;
    logic                   full;
    logic                   out_free;
    logic [2*DATA_W-1:0]    prod;
    data_t                  a_mag;
    data_t                  b_mag;
    logic [DATA_W:0]        div_shift;
    logic [DATA_W:0]        div_diff;

    assign is_digit = (sym_reg >= CH_ZERO) && (sym_reg < (CH_ZERO + SYM_W'(RADIX)));
    assign is_op    = (sym_reg == CH_PLUS) || (sym_reg == CH_MINUS) ||
                      (sym_reg == CH_MUL) || (sym_reg == CH_DIV);
    assign full     = (depth_reg == DW'(STACK_DEPTH));
    assign out_free = !m_valid_reg || m_ready;
    assign prod     = a_reg * b_reg;
    assign a_mag    = a_reg[DATA_W-1] ? (DATA_W'(0) - a_reg) : a_reg;
    assign b_mag    = b_reg[DATA_W-1] ? (DATA_W'(0) - b_reg) : b_reg;
    assign div_shift = {rem_reg, quo_reg[DATA_W-1]};
    assign div_diff  = div_shift - {1'b0, dvs_reg};

    assign s_ready               = (state_reg == S_IDLE);
    assign m_valid               = m_valid_reg;
    assign m_answer              = m_answer_reg;
    assign m_answer_valid        = m_aval_reg;
    assign m_divide_by_zero_seen = m_dz_reg;
    assign m_stack_overflow_seen = m_ov_reg;

    always_comb begin
        state_next    = state_reg;
        sym_next      = sym_reg;
        eoe_next      = eoe_reg;
        depth_next    = depth_reg;
        dz_next       = dz_reg;
        ov_next       = ov_reg;
        a_next        = a_reg;
        b_next        = b_reg;
        res_next      = res_reg;
        rem_next      = rem_reg;
        quo_next      = quo_reg;
        dvs_next      = dvs_reg;
        neg_next      = neg_reg;
        cnt_next      = cnt_reg;
        m_valid_next  = m_valid_reg && !m_ready;
        m_answer_next = m_answer_reg;
        m_aval_next   = m_aval_reg;
        m_dz_next     = m_dz_reg;
        m_ov_next     = m_ov_reg;
        mem_we        = 1'b0;
        mem_waddr     = depth_reg[AW-1:0];
        mem_wdata     = res_reg;
        mem_re        = 1'b0;
        mem_raddr     = AW'(depth_reg - DW'(1));

        case (state_reg)
            S_IDLE: begin
                if (s_valid) begin
                    sym_next   = s_symbol;
                    eoe_next   = s_end_of_expression;
                    state_next = S_DECODE;
                end
            end
            S_DECODE: begin
                state_next = S_FINISH;
                if (is_digit) begin
                    if (full) begin
                        ov_next = 1'b1;
                    end else begin
                        mem_we     = 1'b1;
                        mem_wdata  = DATA_W'(sym_reg - CH_ZERO);
                        depth_next = depth_reg + DW'(1);
                    end
                end else if (is_op && (depth_reg >= DW'(2))) begin
                    mem_re     = 1'b1;
                    state_next = S_RD_B;
                end
            end
            S_RD_B: begin
                b_next     = rd_data_reg;
                mem_re     = 1'b1;
                mem_raddr  = AW'(depth_reg - DW'(2));
                state_next = S_RD_A;
            end
            S_RD_A: begin
                a_next     = rd_data_reg;
                depth_next = depth_reg - DW'(2);
                state_next = S_EXEC;
            end
            S_EXEC: begin
                state_next = S_WR;
                if (sym_reg == CH_PLUS) begin
                    res_next = a_reg + b_reg;
                end else if (sym_reg == CH_MINUS) begin
                    res_next = a_reg - b_reg;
                end else if (sym_reg == CH_MUL) begin
                    res_next = prod[DATA_W-1:0];
                end else if (b_reg == '0) begin
                    dz_next    = 1'b1;
                    state_next = S_FINISH;
                end else begin
                    rem_next   = '0;
                    quo_next   = a_mag;
                    dvs_next   = b_mag;
                    neg_next   = a_reg[DATA_W-1] ^ b_reg[DATA_W-1];
                    cnt_next   = '0;
                    state_next = S_DIV;
                end
            end
            S_DIV: begin
                if (!div_diff[DATA_W]) begin
                    rem_next = div_diff[DATA_W-1:0];
                    quo_next = {quo_reg[DATA_W-2:0], 1'b1};
                end else begin
                    rem_next = div_shift[DATA_W-1:0];
                    quo_next = {quo_reg[DATA_W-2:0], 1'b0};
                end
                cnt_next = cnt_reg + DIV_CNT_W'(1);
                if (cnt_reg == '1) begin
                    state_next = S_FIX;
                end
            end
            S_FIX: begin
                res_next   = neg_reg ? (DATA_W'(0) - quo_reg) : quo_reg;
                state_next = S_WR;
            end
            S_WR: begin
                mem_we     = 1'b1;
                depth_next = depth_reg + DW'(1);
                state_next = S_FINISH;
            end
            S_FINISH: begin
                if (!eoe_reg) begin
                    state_next = S_IDLE;
                end else begin
                    mem_re     = (depth_reg != '0);
                    state_next = S_OUT;
                end
            end
            S_OUT: begin
                if (out_free) begin
                    m_valid_next  = 1'b1;
                    m_answer_next = (depth_reg != '0) ? rd_data_reg : '0;
                    m_aval_next   = (depth_reg != '0);
                    m_dz_next     = dz_reg;
                    m_ov_next     = ov_reg;
                    depth_next    = '0;
                    dz_next       = 1'b0;
                    ov_next       = 1'b0;
                    state_next    = S_IDLE;
                end
            end
            default: begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (mem_we) begin
            mem[mem_waddr] <= mem_wdata;
        end
        if (mem_re) begin
            rd_data_reg <= mem[mem_raddr];
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= S_IDLE;
            depth_reg   <= '0;
            dz_reg      <= 1'b0;
            ov_reg      <= 1'b0;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg   <= state_next;
            depth_reg   <= depth_next;
            dz_reg      <= dz_next;
            ov_reg      <= ov_next;
            m_valid_reg <= m_valid_next;
        end
        sym_reg      <= sym_next;
        eoe_reg      <= eoe_next;
        a_reg        <= a_next;
        b_reg        <= b_next;
        res_reg      <= res_next;
        rem_reg      <= rem_next;
        quo_reg      <= quo_next;
        dvs_reg      <= dvs_next;
        neg_reg      <= neg_next;
        cnt_reg      <= cnt_next;
        m_answer_reg <= m_answer_next;
        m_aval_reg   <= m_aval_next;
        m_dz_reg     <= m_dz_next;
        m_ov_reg     <= m_ov_next;
    end

    a_depth_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        depth_reg <= DW'(STACK_DEPTH))
        else $error("stack depth beyond capacity");

    a_write_in_range: assert property (@(posedge aclk) disable iff (!aresetn)
        mem_we |-> (depth_reg < DW'(STACK_DEPTH)))
        else $error("stack write past capacity");

    a_operands_present: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == S_RD_B) |-> (depth_reg >= DW'(2)))
        else $error("operand read with fewer than two entries");

    a_div_done: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == S_DIV && cnt_reg == '1) |=> (state_reg == S_FIX))
        else $error("divider did not finish after last step");

    a_clear_after_answer: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == S_OUT && out_free) |=>
            (depth_reg == '0 && !dz_reg && !ov_reg && m_valid_reg))
        else $error("state not cleared after answer");

endmodule
